// ===== sv/hwcp_pkg.sv =====
// Package for the hex write command line parser.
// Holds sizes, result and command codes, the command struct and the hex digit decoder.
// No dependencies.
package hwcp_pkg;

  localparam int LINE_LEN   = 8;
  localparam int ADDR_WIDTH = 10;
  localparam int DATA_W     = 8;
  localparam int KIND_W     = 4;
  localparam int LEN_W      = $clog2(LINE_LEN + 1);
  localparam int IDX_W      = $clog2(LINE_LEN);
  localparam int CMD_DEPTH  = 2;
  localparam int PADDR_W    = 3;

  localparam logic [7:0] ENTER_RESET = 8'd13;
  localparam logic [7:0] ERASE_RESET = 8'd127;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;

  // register indexes (byte address bit 2)
  localparam logic REG_ENTER = 1'b0;
  localparam logic REG_ERASE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    K_NONE          = 4'd0,
    K_ECHO          = 4'd1,
    K_ERASE         = 4'd2,
    K_WRITE         = 4'd3,
    K_BAD_START     = 4'd4,
    K_BAD_ADDR_CHAR = 4'd5,
    K_ADDR_RANGE    = 4'd6,
    K_EMPTY_DATA    = 4'd7,
    K_BAD_DATA_CHAR = 4'd8,
    K_DATA_RANGE    = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_ERASE = 2'd1,
    OP_ENTER = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  // Bit 4 set: not a hex digit. Otherwise bits 3:0 hold the digit value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

// ===== sv/hwcp_front.sv =====
// Front end of the parser: accepts received bytes and classifies each one.
// Depends on hwcp_pkg; feeds hwcp_cmd_queue.
module hwcp_front (
  input  logic           push,
  input  logic [7:0]     rx_byte,
  output logic           full,
  input  logic [7:0]     enter_code,
  input  logic [7:0]     erase_code,
  input  logic           q_full,
  output logic           q_wr,
  output hwcp_pkg::cmd_t q_wdata
);
  import hwcp_pkg::*;

  // enter wins over erase when both codes match
  always_comb begin
    q_wdata.ch = rx_byte;
    if (rx_byte == enter_code) begin
      q_wdata.op = OP_ENTER;
    end else if (rx_byte == erase_code) begin
      q_wdata.op = OP_ERASE;
    end else begin
      q_wdata.op = OP_CHAR;
    end
  end

  assign full = q_full;
  assign q_wr = push && !q_full;

endmodule

// ===== sv/hwcp_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on hwcp_pkg.
module hwcp_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  hwcp_pkg::cmd_t wdata,
  input  logic           rd,
  output hwcp_pkg::cmd_t rdata,
  output logic           full,
  output logic           not_empty
);
  import hwcp_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full      = (count == CNT_W'(CMD_DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rdata     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/hwcp_back.sv =====
// Back end of the parser: line buffer, one-character-per-cycle line parser
// and the result register. Depends on hwcp_pkg; fed by hwcp_cmd_queue.
module hwcp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  hwcp_pkg::cmd_t                 cmd,
  output logic                           cmd_rd,
  input  logic                           pop,
  output logic                           empty,
  output logic [hwcp_pkg::KIND_W-1:0]    kind,
  output logic [7:0]                     echo_char,
  output logic [hwcp_pkg::ADDR_WIDTH-1:0] write_addr,
  output logic [hwcp_pkg::DATA_W-1:0]    write_data
);
  import hwcp_pkg::*;

  typedef enum logic {S_IDLE, S_PARSE} state_t;
  typedef enum logic {PH_ADDR, PH_DATA} phase_t;

  state_t                state;
  phase_t                phase;
  logic [LEN_W-1:0]      pos;
  logic [LEN_W-1:0]      length;
  logic [ADDR_WIDTH-1:0] acc_addr;
  logic [DATA_W-1:0]     acc_data;
  logic                  over;
  logic [7:0]            line_buf [LINE_LEN];

  logic                  out_valid;
  kind_t                 out_kind;
  logic [7:0]            out_echo;
  logic [ADDR_WIDTH-1:0] out_addr;
  logic [DATA_W-1:0]     out_data;

  logic [7:0]            cur_ch;
  logic                  at_end;
  logic                  is_sep;
  logic [4:0]            dig;
  logic                  bad;
  logic [ADDR_WIDTH+3:0] addr_sum;
  logic [DATA_W+3:0]     data_sum;
  logic                  step_done;
  kind_t                 step_kind;
  logic                  step_to_data;
  logic                  take;
  logic                  store_ch;

  // current character under the parse pointer
  assign cur_ch   = line_buf[pos[IDX_W-1:0]];
  assign at_end   = (pos >= length) || (cur_ch == 8'h00);
  assign is_sep   = at_end || (cur_ch == SPACE_CHAR);
  assign dig      = hex_digit(cur_ch);
  assign bad      = dig[4];
  assign addr_sum = {acc_addr, dig[3:0]};
  assign data_sum = {acc_data, dig[3:0]};

  // one parse step
  always_comb begin
    step_done    = 1'b0;
    step_kind    = K_NONE;
    step_to_data = 1'b0;
    case (phase)
      PH_ADDR: begin
        if (pos == '0 && (is_sep || bad)) begin
          step_done = 1'b1;
          step_kind = K_BAD_START;
        end else if (is_sep) begin
          if (over) begin
            step_done = 1'b1;
            step_kind = K_ADDR_RANGE;
          end else if (at_end) begin
            step_done = 1'b1;
            step_kind = K_EMPTY_DATA;
          end else begin
            step_to_data = 1'b1;
          end
        end else if (bad) begin
          step_done = 1'b1;
          step_kind = K_BAD_ADDR_CHAR;
        end
      end
      PH_DATA: begin
        if (is_sep) begin
          step_done = 1'b1;
          step_kind = over ? K_DATA_RANGE : K_WRITE;
        end else if (bad) begin
          step_done = 1'b1;
          step_kind = K_BAD_DATA_CHAR;
        end
      end
      default: begin
        step_done = 1'b1;
        step_kind = K_BAD_START;
      end
    endcase
  end

  // a command is taken only when the result register is free
  assign take     = (state == S_IDLE) && cmd_valid && !out_valid;
  assign cmd_rd   = take;
  assign store_ch = take && (cmd.op == OP_CHAR) && (length < LEN_W'(LINE_LEN));

  // line buffer, no reset: only entries below length are read
  always_ff @(posedge clk) begin
    if (store_ch) begin
      line_buf[length[IDX_W-1:0]] <= cmd.ch;
    end
  end

  // sequencer, line length and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            out_echo <= '0;
            out_addr <= '0;
            out_data <= '0;
            case (cmd.op)
              OP_CHAR: begin
                out_valid <= 1'b1;
                if (store_ch) begin
                  length   <= length + LEN_W'(1);
                  out_kind <= K_ECHO;
                  out_echo <= cmd.ch;
                end else begin
                  out_kind <= K_NONE;
                end
              end
              OP_ERASE: begin
                out_valid <= 1'b1;
                if (length != '0) begin
                  length   <= length - LEN_W'(1);
                  out_kind <= K_ERASE;
                end else begin
                  out_kind <= K_NONE;
                end
              end
              OP_ENTER: begin
                state    <= S_PARSE;
                phase    <= PH_ADDR;
                pos      <= '0;
                over     <= 1'b0;
                acc_addr <= '0;
                acc_data <= '0;
              end
              default: begin
                out_valid <= 1'b1;
                out_kind  <= K_NONE;
              end
            endcase
          end
        end
        S_PARSE: begin
          if (step_done) begin
            out_valid <= 1'b1;
            out_kind  <= step_kind;
            out_echo  <= '0;
            out_addr  <= (step_kind == K_WRITE) ? acc_addr : '0;
            out_data  <= (step_kind == K_WRITE) ? acc_data : '0;
            length    <= '0;
            state     <= S_IDLE;
          end else if (step_to_data) begin
            phase    <= PH_DATA;
            pos      <= pos + LEN_W'(1);
            over     <= 1'b0;
            acc_data <= '0;
          end else if (phase == PH_ADDR) begin
            // shift in a digit; range overflow is sticky for the field
            pos      <= pos + LEN_W'(1);
            acc_addr <= addr_sum[ADDR_WIDTH-1:0];
            over     <= over || (addr_sum[ADDR_WIDTH+3:ADDR_WIDTH] != 4'd0);
          end else begin
            pos      <= pos + LEN_W'(1);
            acc_data <= data_sum[DATA_W-1:0];
            over     <= over || (data_sum[DATA_W+3:DATA_W] != 4'd0);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty      = !out_valid;
  assign kind       = out_kind;
  assign echo_char  = out_echo;
  assign write_addr = out_addr;
  assign write_data = out_data;

endmodule

// ===== sv/hex_write_command_line_parser_top.sv =====
// Hex write command line parser, top level.
//
// Input queue side: push / full with rx_byte, one received character per item.
// Result queue side: empty / pop with kind, echo_char, write_addr, write_data;
// exactly one result per accepted item, in order.
// Configuration: APB-style port, enter_code at address 0, erase_code at 4.
// Writes complete in the access cycle; pready is tied high.
//
// An ordinary or erase byte is registered in the command queue and then in
// the result register. The enter byte walks the line one character per cycle,
// up to LINE_LEN + 1 steps, before its result is registered.
// The back end takes no new command until the result held in the single result
// register is popped; a two-entry command queue absorbs bursts on the input.
// Reset (rst, synchronous): line empty, queues empty, enter_code 13,
// erase_code 127. If pop stays low, the result waits, the back end stops
// taking commands, and full rises once the command queue fills.
// Depends on hwcp_pkg, hwcp_front, hwcp_cmd_queue, hwcp_back.
module hex_write_command_line_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      rx_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [hwcp_pkg::KIND_W-1:0]     kind,
  output logic [7:0]                      echo_char,
  output logic [hwcp_pkg::ADDR_WIDTH-1:0] write_addr,
  output logic [hwcp_pkg::DATA_W-1:0]     write_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hwcp_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import hwcp_pkg::*;

  logic [7:0] enter_code;
  logic [7:0] erase_code;
  logic       cfg_wr;
  logic       q_full;
  logic       q_wr;
  cmd_t       q_wdata;
  logic       q_rd;
  cmd_t       q_rdata;
  logic       q_not_empty;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_code <= ENTER_RESET;
      erase_code <= ERASE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ENTER) begin
        enter_code <= pwdata[7:0];
      end else begin
        erase_code <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ERASE) ? {24'd0, erase_code} : {24'd0, enter_code};

  hwcp_front u_front (
    .push       (push),
    .rx_byte    (rx_byte),
    .full       (full),
    .enter_code (enter_code),
    .erase_code (erase_code),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_wdata    (q_wdata)
  );

  hwcp_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wdata     (q_wdata),
    .rd        (q_rd),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  hwcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_not_empty),
    .cmd        (q_rdata),
    .cmd_rd     (q_rd),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .echo_char  (echo_char),
    .write_addr (write_addr),
    .write_data (write_data)
  );

`ifndef SYNTH
  // address and data are only reported with a write request
  a_write_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_WRITE) |-> (write_addr == '0 && write_data == '0))
    else $error("address or data set on a result that is not a write");

  // echo character only accompanies an echo result
  a_echo_field: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_ECHO) |-> (echo_char == 8'd0))
    else $error("echo character set on a result that is not an echo");

  // the result register refills only once it has been emptied
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty)
    else $error("result register reloaded in the cycle it was popped");

  // no result kind outside the defined codes
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind <= K_DATA_RANGE))
    else $error("result kind out of range");
`endif

endmodule
